### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GDAD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// An antecedent that forces the consequent in the next cycle.
`define GDAD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/gdad_pkg.sv
// ---------------------------------------------------------------------------
// gdad_pkg
// Types, constants and calendar helpers for the date adder.
// ---------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned DAYS_WIDTH = 20;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned YLEN_W     = 9;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [YLEN_W-1:0] YEAR_DAYS      = YLEN_W'(365);
  localparam logic [YLEN_W-1:0] LEAP_YEAR_DAYS = YLEN_W'(366);
  localparam logic [DAY_W-1:0]  LEAP_FEB_DAYS  = DAY_W'(29);
  localparam logic [DAY_W-1:0]  FEB_DAYS       = DAY_W'(28);
  localparam logic [DAY_W-1:0]  LONG_MONTH     = DAY_W'(31);
  localparam logic [DAY_W-1:0]  SHORT_MONTH    = DAY_W'(30);

  // Multiplicative inverse of 25 modulo 2^14: y is a multiple of 25 exactly
  // when y * INV25 (mod 2^14) does not exceed floor((2^14 - 1) / 25).
  localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
  localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic prep;
    logic year_step;
    logic month_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic year_go;
    logic month_go;
    logic out_free;
  } status_t;

  // Divisible by 400 is divisible by 16 and 25; by 100 is by 4 and 25.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = (2*YEAR_W)'(y) * (2*YEAR_W)'(INV25);
    div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic               leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LONG_MONTH;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = SHORT_MONTH;
      4'd2:                                       len = leap ? LEAP_FEB_DAYS : FEB_DAYS;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

endpackage

### design/gdad_in_if.sv
// ---------------------------------------------------------------------------
// gdad_in_if / gdad_out_if
// Valid/ready channels for start dates and result dates.
// ---------------------------------------------------------------------------
interface gdad_in_if #(
  parameter int unsigned DAYS_WIDTH = gdad_pkg::DAYS_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic [gdad_pkg::YEAR_W-1:0]    start_year;
  logic [gdad_pkg::MONTH_W-1:0]   start_month;
  logic [gdad_pkg::DAY_W-1:0]     start_day;
  logic [DAYS_WIDTH-1:0]          days_to_add;

  modport source (output valid, start_year, start_month, start_day, days_to_add,
                  input ready);
  modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                  output ready);
endinterface

interface gdad_out_if;
  logic                         valid;
  logic                         ready;
  logic [gdad_pkg::YEAR_W-1:0]  result_year;
  logic [gdad_pkg::MONTH_W-1:0] result_month;
  logic [gdad_pkg::DAY_W-1:0]   result_day;

  modport source (output valid, result_year, result_month, result_day, input ready);
  modport sink   (input valid, result_year, result_month, result_day, output ready);
endinterface

### design/gregorian_date_add_days.sv
// ---------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date: whole years, whole months, then days.
// ---------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  in_i     in   start_year, start_month, start_day, days_to_add
//  out_o    out  result_year, result_month, result_day
//
//  An item is loaded on acceptance, its leap flags are prepared, then the year
//  loop skips Y whole years (up to about 2^DAYS_WIDTH / 365) and the month loop
//  M whole months (at most 12), and the finish step writes the result.
//  The input reopens as the result is written. The result register lets the
//  next beat in while a result waits, but that item's last step stalls until
//  the register is free. Reset clears the sequencer and the result valid.
// ---------------------------------------------------------------------------
module gregorian_date_add_days #(
  parameter int unsigned DAYS_WIDTH = gdad_pkg::DAYS_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gdad_in_if.sink    in_i,
  gdad_out_if.source out_o
);

  gdad_pkg::cmd_t    cmd;
  gdad_pkg::status_t status;

  gdad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gdad_dpath #(
    .DAYS_WIDTH (DAYS_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .start_year_i   (in_i.start_year),
    .start_month_i  (in_i.start_month),
    .start_day_i    (in_i.start_day),
    .days_to_add_i  (in_i.days_to_add),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_year_o  (out_o.result_year),
    .result_month_o (out_o.result_month),
    .result_day_o   (out_o.result_day)
  );

  assign in_i.ready = cmd.in_ready;

endmodule

### design/gdad_ctrl.sv
// ---------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: load, prepare leap flags, skip years, skip months, finish.
// ---------------------------------------------------------------------------
module gdad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  gdad_pkg::status_t status_i,
  output gdad_pkg::cmd_t    cmd_o
);

  gdad_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gdad_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gdad_pkg::ST_PREP;
      end
      gdad_pkg::ST_PREP:  state_d = gdad_pkg::ST_YEAR;
      gdad_pkg::ST_YEAR: begin
        if (!status_i.year_go) state_d = gdad_pkg::ST_MONTH;
      end
      gdad_pkg::ST_MONTH: begin
        if (!status_i.month_go) state_d = gdad_pkg::ST_FINISH;
      end
      gdad_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = gdad_pkg::ST_IDLE;
      end
      default: state_d = gdad_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      gdad_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = in_valid_i;
      end
      gdad_pkg::ST_PREP:   cmd_o.prep       = 1'b1;
      gdad_pkg::ST_YEAR:   cmd_o.year_step  = status_i.year_go;
      gdad_pkg::ST_MONTH:  cmd_o.month_step = status_i.month_go;
      gdad_pkg::ST_FINISH: cmd_o.finish     = status_i.out_free;
      default:             cmd_o = '0;
    endcase
  end

endmodule

### design/gdad_dpath.sv
// ---------------------------------------------------------------------------
// gdad_dpath
// Date registers, remaining-day counter, leap flags and the result register.
// ---------------------------------------------------------------------------
module gdad_dpath #(
  parameter int unsigned DAYS_WIDTH = gdad_pkg::DAYS_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gdad_pkg::cmd_t               cmd_i,
  output gdad_pkg::status_t            status_o,
  input  logic [gdad_pkg::YEAR_W-1:0]  start_year_i,
  input  logic [gdad_pkg::MONTH_W-1:0] start_month_i,
  input  logic [gdad_pkg::DAY_W-1:0]   start_day_i,
  input  logic [DAYS_WIDTH-1:0]        days_to_add_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gdad_pkg::YEAR_W-1:0]  result_year_o,
  output logic [gdad_pkg::MONTH_W-1:0] result_month_o,
  output logic [gdad_pkg::DAY_W-1:0]   result_day_o
);

  localparam int unsigned YW = gdad_pkg::YEAR_W;
  localparam int unsigned MW = gdad_pkg::MONTH_W;
  localparam int unsigned DW = gdad_pkg::DAY_W;

  logic [YW-1:0]         year_q, out_year_q;
  logic [MW-1:0]         month_q, out_month_q;
  logic [DW-1:0]         day_q, out_day_q;
  logic [DAYS_WIDTH-1:0] rest_q;
  logic                  leap_cur_q, leap_nxt_q;
  logic                  out_valid_q;

  logic [YW-1:0]                 year_inc, year_inc2;
  logic                          month_wrap;
  logic [MW-1:0]                 month_nx;
  logic [DW-1:0]                 mlen;
  logic [gdad_pkg::YLEN_W-1:0]   ylen;
  logic                          skip_leap;
  logic [DW:0]                   day_sum;
  logic                          day_over;

  assign year_inc   = year_q + YW'(1);
  assign year_inc2  = year_q + YW'(2);
  // Months 12 to 15 all roll into January of the following year.
  assign month_wrap = (month_q >= gdad_pkg::MONTH_DEC);
  assign month_nx   = month_wrap ? gdad_pkg::MONTH_JAN : month_q + MW'(1);

  assign mlen = gdad_pkg::month_days(month_q, leap_cur_q);

  // Past February the year being skipped spans the following year's February.
  assign skip_leap = (month_q > gdad_pkg::MONTH_FEB) ? leap_nxt_q : leap_cur_q;
  assign ylen      = skip_leap ? gdad_pkg::LEAP_YEAR_DAYS : gdad_pkg::YEAR_DAYS;

  // The remainder is below the month length here, so five bits carry it.
  assign day_sum  = {1'b0, day_q} + {1'b0, rest_q[DW-1:0]};
  assign day_over = (day_sum > {1'b0, mlen});

  assign status_o.year_go  = (rest_q >= DAYS_WIDTH'(ylen));
  assign status_o.month_go = (rest_q >= DAYS_WIDTH'(mlen));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q  <= start_year_i;
      month_q <= start_month_i;
      day_q   <= start_day_i;
      rest_q  <= days_to_add_i;
    end
    if (cmd_i.prep) begin
      leap_cur_q <= gdad_pkg::is_leap(year_q);
      leap_nxt_q <= gdad_pkg::is_leap(year_inc);
    end
    if (cmd_i.year_step) begin
      year_q     <= year_inc;
      rest_q     <= rest_q - DAYS_WIDTH'(ylen);
      leap_cur_q <= leap_nxt_q;
      leap_nxt_q <= gdad_pkg::is_leap(year_inc2);
    end
    if (cmd_i.month_step) begin
      month_q <= month_nx;
      rest_q  <= rest_q - DAYS_WIDTH'(mlen);
      if (month_wrap) begin
        year_q     <= year_inc;
        leap_cur_q <= leap_nxt_q;
        leap_nxt_q <= gdad_pkg::is_leap(year_inc2);
      end
    end
    if (cmd_i.finish) begin
      if (day_over) begin
        out_month_q <= month_nx;
        out_year_q  <= month_wrap ? year_inc : year_q;
        out_day_q   <= DW'(day_sum - {1'b0, mlen});
      end else begin
        out_month_q <= month_q;
        out_year_q  <= year_q;
        out_day_q   <= day_sum[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_year_o  = out_year_q;
  assign result_month_o = out_month_q;
  assign result_day_o   = out_day_q;

endmodule

### design/gdad_checker.sv
// ---------------------------------------------------------------------------
// gdad_checker
// Port-level checks on the date adder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gdad_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [gdad_pkg::YEAR_W-1:0]  result_year_i,
  input logic [gdad_pkg::MONTH_W-1:0] result_month_i,
  input logic [gdad_pkg::DAY_W-1:0]   result_day_i
);

  // A stalled result beat keeps its valid and its contents.
  `GDAD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result valid dropped while stalled")
  `GDAD_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(result_year_i) && $stable(result_month_i) && $stable(result_day_i), "result changed while stalled")

  // Only one item is in work, so the input closes right after a beat.
  `GDAD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input open right after an accepted beat")

  // The month loop always ends on a real month, whatever the start month.
  `GDAD_ASSERT(a_month_range, clk_i, rst_ni, !out_valid_i || (result_month_i >= gdad_pkg::MONTH_JAN && result_month_i <= gdad_pkg::MONTH_DEC), "result month out of range")

endmodule

bind gregorian_date_add_days gdad_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_year_i  (out_o.result_year),
  .result_month_i (out_o.result_month),
  .result_day_i   (out_o.result_day)
);
